// ===== hdl/lmls_pkg.sv =====
// Shared types, constants and helpers for the lift, move and lower sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lmls_pkg;

  localparam int unsigned POS_BITS     = 24;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned REG_BITS     = 16;
  localparam int unsigned DIFF_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam int unsigned IN_FIELD_BITS  = TIME_BITS + 9 * POS_BITS;
  localparam int unsigned IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 3 * POS_BITS + 2 + 3 + 1;
  localparam int unsigned OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [POS_BITS-1:0] pos_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    TORQUE_NONE = 2'd0,
    TORQUE_OFF  = 2'd1,
    TORQUE_ON   = 2'd2
  } torque_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LIFT  = 5'b00010,
    PH_MOVE  = 5'b00100,
    PH_LOWER = 5'b01000,
    PH_FIT   = 5'b10000
  } phase_e;

  localparam logic [2:0] PHASE_CODE_IDLE  = 3'd0;
  localparam logic [2:0] PHASE_CODE_LIFT  = 3'd1;
  localparam logic [2:0] PHASE_CODE_MOVE  = 3'd2;
  localparam logic [2:0] PHASE_CODE_LOWER = 3'd3;
  localparam logic [2:0] PHASE_CODE_FIT   = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAISE_H    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAISE_THR  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_THR   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_THR = 3'd4;

  localparam logic [REG_BITS-1:0]   PERIOD_RST     = 16'd100;
  localparam logic [REG_BITS-1:0]   RAISE_H_RST    = 16'd1000;
  localparam logic [REG_BITS-1:0]   RAISE_THR_RST  = 16'd500;
  localparam logic [2*REG_BITS-1:0] MOVE_SQ_RST    = 32'd250000;
  localparam logic [REG_BITS-1:0]   SETTLE_THR_RST = 16'd200;

  typedef struct packed {
    logic [REG_BITS-1:0]   period;
    logic [REG_BITS-1:0]   raise_h;
    logic [REG_BITS-1:0]   raise_thr;
    logic [2*REG_BITS-1:0] move_sq;
    logic [REG_BITS-1:0]   settle_thr;
  } cfg_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic [TIME_BITS-1:0] now;
    pos_t                 meas_z;
    pos_t                 cmd_x;
    pos_t                 cmd_y;
    pos_t                 cmd_z;
    pos_t                 goal_x;
    pos_t                 goal_y;
    pos_t                 goal_z;
    logic [DIFF_BITS-1:0] dx_abs;
    logic [DIFF_BITS-1:0] dy_abs;
    logic                 near;
  } item_t;

  typedef struct packed {
    logic       tgt_valid;
    pos_t       tgt_x;
    pos_t       tgt_y;
    pos_t       tgt_z;
    torque_e    torque;
    logic [2:0] phase;
    logic       busy;
  } res_t;

  function automatic logic [2:0] phase_code(phase_e p);
    logic [2:0] code;
    unique case (p)
      PH_IDLE:  code = PHASE_CODE_IDLE;
      PH_LIFT:  code = PHASE_CODE_LIFT;
      PH_MOVE:  code = PHASE_CODE_MOVE;
      PH_LOWER: code = PHASE_CODE_LOWER;
      PH_FIT:   code = PHASE_CODE_FIT;
      default:  code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/lmls_cfg.sv =====
// Configuration registers of the sequencer, with the squared move threshold
// kept precomputed. Depends on lmls_pkg.
`timescale 1ns / 1ps

module lmls_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lmls_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [lmls_pkg::REG_BITS-1:0]      cfg_data_i,
  output lmls_pkg::cfg_t                     cfg_o
);
  import lmls_pkg::*;

  cfg_t                  cfg_d, cfg_q;
  logic [2*REG_BITS-1:0] thr_sq;

  assign thr_sq = cfg_data_i * cfg_data_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:     cfg_d.period     = cfg_data_i;
        REG_RAISE_H:    cfg_d.raise_h    = cfg_data_i;
        REG_RAISE_THR:  cfg_d.raise_thr  = cfg_data_i;
        REG_MOVE_THR:   cfg_d.move_sq    = thr_sq;
        REG_SETTLE_THR: cfg_d.settle_thr = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period     <= PERIOD_RST;
      cfg_q.raise_h    <= RAISE_H_RST;
      cfg_q.raise_thr  <= RAISE_THR_RST;
      cfg_q.move_sq    <= MOVE_SQ_RST;
      cfg_q.settle_thr <= SETTLE_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lmls_in_stage.sv =====
// Input register: unpacks a request and precomputes the planar offsets.
// Depends on lmls_pkg.
`timescale 1ns / 1ps

module lmls_in_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  input  logic [lmls_pkg::IN_TDATA_BITS-1:0]  s_data_i,
  input  logic                                s_user_i,
  input  logic                                adv_i,
  output logic                                s_ready_o,
  output logic                                valid_o,
  output lmls_pkg::item_t                     item_o
);
  import lmls_pkg::*;

  pos_t                  fld [9];
  logic signed [POS_BITS:0] dx, dy;
  logic [POS_BITS:0]     dx_abs, dy_abs;
  item_t                 item_d, item_q;
  logic                  valid_d, valid_q;
  logic                  fire;

  // Field order after now_ms: meas x/y/z, cmd x/y/z, goal x/y/z
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      fld[k] = s_data_i[TIME_BITS + k * POS_BITS +: POS_BITS];
    end
  end

  assign dx     = {fld[0][POS_BITS-1], fld[0]} - {fld[3][POS_BITS-1], fld[3]};
  assign dy     = {fld[1][POS_BITS-1], fld[1]} - {fld[4][POS_BITS-1], fld[4]};
  assign dx_abs = dx[POS_BITS] ? -dx : dx;
  assign dy_abs = dy[POS_BITS] ? -dy : dy;

  always_comb begin
    item_d.cmd    = cmd_e'(s_user_i);
    item_d.now    = s_data_i[TIME_BITS-1:0];
    item_d.meas_z = fld[2];
    item_d.cmd_x  = fld[3];
    item_d.cmd_y  = fld[4];
    item_d.cmd_z  = fld[5];
    item_d.goal_x = fld[6];
    item_d.goal_y = fld[7];
    item_d.goal_z = fld[8];
    item_d.dx_abs = dx_abs[DIFF_BITS-1:0];
    item_d.dy_abs = dy_abs[DIFF_BITS-1:0];
    // squares are only taken when both offsets fit the register width
    item_d.near   = (dx_abs[POS_BITS:DIFF_BITS] == '0) &&
                    (dy_abs[POS_BITS:DIFF_BITS] == '0);
  end

  assign s_ready_o = !valid_q || adv_i;
  assign fire      = s_valid_i && s_ready_o;
  assign valid_d   = fire || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/lmls_core.sv =====
// Phase machine and sequence state: evaluates one registered request per cycle
// and forms its result; state updates only while adv_i is high. Depends on lmls_pkg.
`timescale 1ns / 1ps

module lmls_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lmls_pkg::cfg_t   cfg_i,
  input  lmls_pkg::item_t  item_i,
  input  logic             adv_i,
  output lmls_pkg::res_t   res_o
);
  import lmls_pkg::*;

  phase_e               phase_d, phase_q;
  logic                 armed_d, armed_q;
  pos_t                 goal_x_d, goal_x_q;
  pos_t                 goal_y_d, goal_y_q;
  pos_t                 goal_z_d, goal_z_q;
  pos_t                 start_z_d, start_z_q;
  pos_t                 last_z_d, last_z_q;
  logic [TIME_BITS-1:0] last_time_d, last_time_q;

  logic [TIME_BITS-1:0]   elapsed;
  logic                   due;
  logic [POS_BITS:0]      raise_sum;
  pos_t                   raise_z;
  logic [POS_BITS:0]      rise;
  logic                   lifted;
  logic [POS_BITS:0]      dz, dz_abs;
  logic                   settled;
  logic [2*DIFF_BITS-1:0] sq_x, sq_y;
  logic [2*DIFF_BITS:0]   dist_sq;
  logic                   arrived;
  res_t                   res;

  assign elapsed = item_i.now - last_time_q;
  assign due     = elapsed >= TIME_BITS'(cfg_i.period);

  // the lift offset is never negative, so only the upper bound can be crossed
  assign raise_sum = {item_i.cmd_z[POS_BITS-1], item_i.cmd_z} +
                     (POS_BITS + 1)'(cfg_i.raise_h);
  assign raise_z   = (raise_sum[POS_BITS] != raise_sum[POS_BITS-1]) ?
                     {1'b0, {(POS_BITS - 1){1'b1}}} : raise_sum[POS_BITS-1:0];

  assign rise   = {item_i.meas_z[POS_BITS-1], item_i.meas_z} -
                  {start_z_q[POS_BITS-1], start_z_q};
  assign lifted = !rise[POS_BITS] &&
                  (rise[POS_BITS-1:0] > POS_BITS'(cfg_i.raise_thr));

  assign dz      = {item_i.meas_z[POS_BITS-1], item_i.meas_z} -
                   {last_z_q[POS_BITS-1], last_z_q};
  assign dz_abs  = dz[POS_BITS] ? -dz : dz;
  assign settled = dz_abs < (POS_BITS + 1)'(cfg_i.settle_thr);

  assign sq_x    = item_i.dx_abs * item_i.dx_abs;
  assign sq_y    = item_i.dy_abs * item_i.dy_abs;
  assign dist_sq = (2 * DIFF_BITS + 1)'(sq_x) + (2 * DIFF_BITS + 1)'(sq_y);
  assign arrived = item_i.near && (dist_sq < (2 * DIFF_BITS + 1)'(cfg_i.move_sq));

  always_comb begin
    phase_d     = phase_q;
    armed_d     = armed_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    goal_z_d    = goal_z_q;
    start_z_d   = start_z_q;
    last_z_d    = last_z_q;
    last_time_d = last_time_q;
    res         = '0;
    res.torque  = TORQUE_NONE;

    if (item_i.cmd == CMD_SET) begin
      goal_x_d = item_i.goal_x;
      goal_y_d = item_i.goal_y;
      goal_z_d = item_i.goal_z;
      armed_d  = 1'b1;
      phase_d  = PH_IDLE;
    end else if (due) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (armed_q) begin
            res.tgt_valid = 1'b1;
            res.tgt_x     = item_i.cmd_x;
            res.tgt_y     = item_i.cmd_y;
            res.tgt_z     = raise_z;
            start_z_d     = item_i.meas_z;
            phase_d       = PH_LIFT;
          end
        end
        PH_LIFT: begin
          if (lifted) begin
            res.tgt_valid = 1'b1;
            res.tgt_x     = goal_x_q;
            res.tgt_y     = goal_y_q;
            res.tgt_z     = item_i.cmd_z;
            phase_d       = PH_MOVE;
          end
        end
        PH_MOVE: begin
          if (arrived) begin
            res.tgt_valid = 1'b1;
            res.tgt_x     = goal_x_q;
            res.tgt_y     = goal_y_q;
            res.tgt_z     = goal_z_q;
            phase_d       = PH_LOWER;
          end
        end
        PH_LOWER: begin
          if (settled) begin
            res.torque = TORQUE_OFF;
            phase_d    = PH_FIT;
          end
        end
        PH_FIT: begin
          if (settled) begin
            res.torque = TORQUE_ON;
            phase_d    = PH_IDLE;
            armed_d    = 1'b0;
          end
        end
        default: ;
      endcase
      last_z_d    = item_i.meas_z;
      last_time_d = item_i.now;
    end

    res.phase = phase_code(phase_d);
    res.busy  = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      armed_q     <= 1'b0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_z_q    <= '0;
      start_z_q   <= '0;
      last_z_q    <= '0;
      last_time_q <= '0;
    end else if (adv_i) begin
      phase_q     <= phase_d;
      armed_q     <= armed_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      goal_z_q    <= goal_z_d;
      start_z_q   <= start_z_d;
      last_z_q    <= last_z_d;
      last_time_q <= last_time_d;
    end
  end

  assign res_o = res;

endmodule

// ===== hdl/lift_move_lower_sequencer_unit.sv =====
// Lift, move and lower sequencer, top level: stream ports, configuration
// registers, input register, phase core and result register.
// Depends on lmls_pkg, lmls_cfg, lmls_in_stage and lmls_core.
//
// Usage:
//   Requests enter on s_axis: tuser is the command (0 tick, 1 set goal), tdata
//   holds now_ms, meas x/y/z, cmd x/y/z and goal x/y/z. Every request gives
//   exactly one result on m_axis: tuser is the new-target flag, tdata holds
//   target x/y/z, torque order, phase and busy flag.
//   From acceptance to m_axis_tvalid a request passes the input register, then
//   the phase logic into the result register. Throughput is one request per
//   cycle while the receiver takes results; the longest path is the squared
//   planar distance (two 16x16 products, an add and a compare).
//   Reset loads the register defaults, returns the phase machine to idle
//   with the sequence disarmed and empties both registers.
//   When the receiver stalls, the result register holds, the input register
//   takes one more request, and s_axis_tready then drops until the result
//   is taken.
//   Write configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while no
//   request is in flight; indexes beyond the register list are ignored.
`timescale 1ns / 1ps

module lift_move_lower_sequencer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // s_axis_tdata, low bit up: now_ms, meas_x, meas_y, meas_z, cmd_x, cmd_y,
  // cmd_z, goal_x, goal_y, goal_z
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lmls_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tuser,   // cmd
  // m_axis_tdata, low bit up: target_x, target_y, target_z, torque_order,
  // phase_now, busy_res, zero fill
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lmls_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  output logic                                 m_axis_tuser,   // new_target_valid
  input  logic                                 cfg_we_i,
  input  logic [lmls_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lmls_pkg::REG_BITS-1:0]        cfg_data_i
);
  import lmls_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  res_q;
  logic  s1_valid;
  logic  adv;
  logic  out_valid_d, out_valid_q;

  lmls_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lmls_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .adv_i     (adv),
    .s_ready_o (s_axis_tready),
    .valid_o   (s1_valid),
    .item_o    (item)
  );

  lmls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .adv_i  (adv),
    .res_o  (res)
  );

  // advance when the input register holds a request and the result register is empty or being drained
  assign adv         = s1_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.tgt_valid;
  assign m_axis_tdata  = OUT_TDATA_BITS'({res_q.busy, res_q.phase, res_q.torque,
                                          res_q.tgt_z, res_q.tgt_y, res_q.tgt_x});

  a_idle_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.busy |-> res_q.phase == PHASE_CODE_IDLE)
    else $error("sequence disarmed outside the idle phase");

  a_target_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.tgt_valid |->
      (res_q.phase == PHASE_CODE_LIFT) || (res_q.phase == PHASE_CODE_MOVE) ||
      (res_q.phase == PHASE_CODE_LOWER))
    else $error("target issued with an unexpected next phase");

  a_torque_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.torque != TORQUE_NONE) |-> !res_q.tgt_valid)
    else $error("torque order and new target in one result");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !adv |=> s1_valid)
    else $error("request dropped from the input register");

endmodule

// ===== tb/sv/tb_lift_move_lower_sequencer_unit.sv =====
// Self-checking bench for lift_move_lower_sequencer_unit: drives set and tick
// requests with random bursts and stalls and checks each result against a model.
// Depends on lmls_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_lift_move_lower_sequencer_unit;
  import lmls_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [REG_BITS-1:0] MOVE_THR_RST = 16'd500;
  localparam pos_t POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef struct {
    cmd_e                 cmd;
    logic [TIME_BITS-1:0] now;
    pos_t                 meas_x, meas_y, meas_z;
    pos_t                 cmd_x, cmd_y, cmd_z;
    pos_t                 goal_x, goal_y, goal_z;
  } request_t;

  typedef struct {
    bit         valid;
    pos_t       x, y, z;
    torque_e    torque;
    logic [2:0] phase;
    bit         busy;
  } target_t;

  class motion_scoreboard;
    logic [REG_BITS-1:0]  period, raise_h, raise_thr, move_thr, settle_thr;
    logic [2:0]           phase;
    bit                   armed;
    pos_t                 goal_x, goal_y, goal_z, start_z, last_z;
    logic [TIME_BITS-1:0] last_ms;
    target_t              pending_targets[$];
    int unsigned          errors, checked, requests, acted, targets, torque_offs, torque_ons;

    function new();
      period     = PERIOD_RST;
      raise_h    = RAISE_H_RST;
      raise_thr  = RAISE_THR_RST;
      move_thr   = MOVE_THR_RST;
      settle_thr = SETTLE_THR_RST;
      phase      = PHASE_CODE_IDLE;
      armed      = 1'b0;
      goal_x     = '0;
      goal_y     = '0;
      goal_z     = '0;
      start_z    = '0;
      last_z     = '0;
      last_ms    = '0;
      errors     = 0;
      checked    = 0;
      requests   = 0;
      acted      = 0;
      targets    = 0;
      torque_offs = 0;
      torque_ons = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
      case (idx)
        REG_PERIOD:     period = val;
        REG_RAISE_H:    raise_h = val;
        REG_RAISE_THR:  raise_thr = val;
        REG_MOVE_THR:   move_thr = val;
        REG_SETTLE_THR: settle_thr = val;
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function pos_t clamp_pos(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return pos_t'(hi);
      if (v < lo) return pos_t'(lo);
      return pos_t'(v);
    endfunction

    // Advance the phase machine by one request and queue the result it gives.
    function void note_request(request_t r);
      target_t              t;
      logic [TIME_BITS-1:0] elapsed;
      longint               dx, dy, dist2, thr2;
      t.valid  = 1'b0;
      t.x      = '0;
      t.y      = '0;
      t.z      = '0;
      t.torque = TORQUE_NONE;
      requests++;
      elapsed = r.now - last_ms;
      if (r.cmd == CMD_SET) begin
        goal_x = r.goal_x;
        goal_y = r.goal_y;
        goal_z = r.goal_z;
        armed  = 1'b1;
        phase  = PHASE_CODE_IDLE;
        acted++;
      end else if (elapsed >= TIME_BITS'(period)) begin
        acted++;
        case (phase)
          PHASE_CODE_IDLE: if (armed) begin
            t.valid = 1'b1;
            t.x = r.cmd_x;
            t.y = r.cmd_y;
            t.z = clamp_pos(longint'(r.cmd_z) + longint'(raise_h));
            start_z = r.meas_z;
            phase = PHASE_CODE_LIFT;
          end
          PHASE_CODE_LIFT:
            if (longint'(r.meas_z) - longint'(start_z) > longint'(raise_thr)) begin
              t.valid = 1'b1;
              t.x = goal_x;
              t.y = goal_y;
              t.z = r.cmd_z;
              phase = PHASE_CODE_MOVE;
            end
          PHASE_CODE_MOVE: begin
            dx = mag(longint'(r.meas_x) - longint'(r.cmd_x));
            dy = mag(longint'(r.meas_y) - longint'(r.cmd_y));
            // large offsets never count as arrived, whatever the threshold
            if (dx < 65536 && dy < 65536) begin
              dist2 = dx * dx + dy * dy;
              thr2 = longint'(move_thr) * longint'(move_thr);
              if (dist2 < thr2) begin
                t.valid = 1'b1;
                t.x = goal_x;
                t.y = goal_y;
                t.z = goal_z;
                phase = PHASE_CODE_LOWER;
              end
            end
          end
          PHASE_CODE_LOWER:
            if (mag(longint'(r.meas_z) - longint'(last_z)) < longint'(settle_thr)) begin
              t.torque = TORQUE_OFF;
              phase = PHASE_CODE_FIT;
            end
          PHASE_CODE_FIT:
            if (mag(longint'(r.meas_z) - longint'(last_z)) < longint'(settle_thr)) begin
              t.torque = TORQUE_ON;
              phase = PHASE_CODE_IDLE;
              armed = 1'b0;
            end
          default: ;
        endcase
        last_z  = r.meas_z;
        last_ms = r.now;
      end
      t.phase = phase;
      t.busy  = armed;
      if (t.valid) targets++;
      if (t.torque == TORQUE_OFF) torque_offs++;
      if (t.torque == TORQUE_ON) torque_ons++;
      pending_targets.push_back(t);
    endfunction

    function void match_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic flag, logic [OUT_TDATA_BITS-1:0] d);
      target_t t;
      if (pending_targets.size() == 0) begin
        errors++;
        $display("%0t: result with no request awaiting it, tdata %h", $time, d);
        return;
      end
      t = pending_targets.pop_front();
      checked++;
      match_field("new_target_valid", longint'(t.valid), longint'(flag));
      match_field("target_x", longint'(t.x), longint'(pos_t'(d[0 +: POS_BITS])));
      match_field("target_y", longint'(t.y), longint'(pos_t'(d[POS_BITS +: POS_BITS])));
      match_field("target_z", longint'(t.z), longint'(pos_t'(d[2*POS_BITS +: POS_BITS])));
      match_field("torque_order", longint'(t.torque), longint'(d[3*POS_BITS +: 2]));
      match_field("phase_now", longint'(t.phase), longint'(d[3*POS_BITS+2 +: 3]));
      match_field("busy_res", longint'(t.busy), longint'(d[3*POS_BITS+5]));
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [IN_TDATA_BITS-1:0]    s_axis_tdata = '0;
  logic                        s_axis_tuser = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;
  logic                        m_axis_tuser;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_idx_i = '0;
  logic [REG_BITS-1:0]         cfg_data_i = '0;

  motion_scoreboard sb;

  int unsigned burst_left = 0;
  int unsigned steady_left = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned quiet_cycles = 0;

  // shape stimulus after the register values last written
  int unsigned cur_period = PERIOD_RST;
  int unsigned cur_raise_thr = RAISE_THR_RST;
  int unsigned cur_move = MOVE_THR_RST;
  int unsigned cur_settle = SETTLE_THR_RST;

  lift_move_lower_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic pos_t rand_pos();
    return pos_t'($urandom);
  endfunction

  function automatic int spread(int unsigned a);
    return int'($urandom_range(2 * a)) - int'(a);
  endfunction

  function automatic request_t make_req(cmd_e c, logic [TIME_BITS-1:0] now,
                                        pos_t mx, pos_t my, pos_t mz,
                                        pos_t cx, pos_t cy, pos_t cz,
                                        pos_t gx, pos_t gy, pos_t gz);
    request_t r;
    r.cmd    = c;
    r.now    = now;
    r.meas_x = mx;
    r.meas_y = my;
    r.meas_z = mz;
    r.cmd_x  = cx;
    r.cmd_y  = cy;
    r.cmd_z  = cz;
    r.goal_x = gx;
    r.goal_y = gy;
    r.goal_z = gz;
    return r;
  endfunction

  // Offer one request, with a random gap at the start of each burst.
  task automatic send_request(input request_t r);
    logic [IN_TDATA_BITS-1:0] d;
    int unsigned              gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 1);
      if (steady_left == 0 && gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    if (steady_left != 0) steady_left--;
    d = '0;
    d[0 +: TIME_BITS] = r.now;
    d[TIME_BITS +: POS_BITS] = r.meas_x;
    d[TIME_BITS + POS_BITS +: POS_BITS] = r.meas_y;
    d[TIME_BITS + 2*POS_BITS +: POS_BITS] = r.meas_z;
    d[TIME_BITS + 3*POS_BITS +: POS_BITS] = r.cmd_x;
    d[TIME_BITS + 4*POS_BITS +: POS_BITS] = r.cmd_y;
    d[TIME_BITS + 5*POS_BITS +: POS_BITS] = r.cmd_z;
    d[TIME_BITS + 6*POS_BITS +: POS_BITS] = r.goal_x;
    d[TIME_BITS + 7*POS_BITS +: POS_BITS] = r.goal_y;
    d[TIME_BITS + 8*POS_BITS +: POS_BITS] = r.goal_z;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic pause_stream();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_targets.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: check accepted results, then stall on its own pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 90;
        m_axis_tready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(3);
          stall_left = $urandom_range(64, 4);
        end
        stall_left--;
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(3) != 0);
          2:       m_axis_tready <= ($urandom_range(3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending_targets.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [REG_BITS-1:0]     cfg_vals [5];
    logic [CFG_IDX_BITS-1:0] reg_ids [5];
    logic [CFG_IDX_BITS-1:0] idx;
    logic [REG_BITS-1:0]     val;
    logic [TIME_BITS-1:0]    clock_ms;
    pos_t                    body_z, nav_x, nav_y, nav_z, mx, my, gx, gy, gz;
    int unsigned             goal, n, settings;
    int                      i, j, k;

    sb = new();
    reg_ids = '{REG_PERIOD, REG_RAISE_H, REG_RAISE_THR, REG_MOVE_THR, REG_SETTLE_THR};
    body_z = '0;
    nav_x = '0;
    nav_y = '0;
    nav_z = '0;
    settings = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk through every phase at the reset settings
    send_request(make_req(CMD_TICK, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd99, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd100, 0, 0, -1000, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_SET, 32'hFFFF_FFFF, POS_MIN, POS_MIN, POS_MIN,
                          POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
    // raised height saturates at the top of the range
    send_request(make_req(CMD_TICK, 32'd200, 0, 0, -1000, POS_MAX, POS_MIN, POS_MAX,
                          0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd250, 0, 0, 5000, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd300, 0, 0, -500, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd400, 0, 0, -499, 0, 0, 1234, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd500, POS_MAX, 0, 0, POS_MIN, 0, 0, 0, 0, 0));
    // distance exactly on the threshold is not arrived, one less is
    send_request(make_req(CMD_TICK, 32'd600, 1300, -400, 0, 1000, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd700, 700, 399, 0, 1000, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd800, 0, 0, 200, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd900, 0, 0, 399, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd1000, 0, 0, POS_MIN, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd1100, 0, 0, pos_t'(POS_MIN + 108),
                          0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'd1200, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_SET, 32'd0, 0, 0, 0, 0, 0, 0, POS_MIN, POS_MIN, POS_MIN));
    // time wraps between these two ticks
    send_request(make_req(CMD_TICK, 32'hFFFF_FFC0, 0, 0, POS_MIN, POS_MAX, POS_MIN, POS_MIN,
                          0, 0, 0));
    send_request(make_req(CMD_TICK, 32'h0000_0024, 0, 0, pos_t'(POS_MIN + 501),
                          0, 0, -5, 0, 0, 0));
    // a new goal in the middle of a sequence restarts it
    send_request(make_req(CMD_SET, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_TICK, 32'h0000_0088, 0, 0, 0, 0, 0, pos_t'(POS_MAX - 999),
                          0, 0, 0));
    send_request(make_req(CMD_TICK, 32'h0000_00EC, 0, 0, 501, 0, 0, 0, 0, 0, 0));
    pause_stream();

    goal = sb.acted;
    for (k = 0; k < 8; k++) begin
      case (k)
        0:       cfg_vals = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
        1:       cfg_vals = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0};
        default: cfg_vals = '{16'($urandom_range(300)), 16'($urandom),
                              16'($urandom_range(4000)), 16'($urandom_range(3000, 1)),
                              16'($urandom_range(800, 1))};
      endcase
      // write every register, then one index past the list that must be ignored
      for (i = 0; i < 6; i++) begin
        if (i < 5) begin
          idx = reg_ids[i];
          val = cfg_vals[reg_ids[i]];
        end else begin
          idx = REG_SETTLE_THR + CFG_IDX_BITS'($urandom_range(3, 1));
          val = REG_BITS'($urandom);
        end
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= idx;
        cfg_data_i <= val;
        @(posedge clk_i);
        sb.write_reg(idx, val);
      end
      cfg_we_i <= 1'b0;
      settings++;
      cur_period    = cfg_vals[REG_PERIOD];
      cur_raise_thr = cfg_vals[REG_RAISE_THR];
      cur_move      = cfg_vals[REG_MOVE_THR];
      cur_settle    = cfg_vals[REG_SETTLE_THR];
      clock_ms = (k % 2 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(5000);

      if (k == 2) begin
        // long receiver hold while requests keep coming back to back
        hold_request = 1'b1;
        steady_left = 48;
      end

      goal += 240;
      while (sb.acted < goal) begin
        if ($urandom_range(99) < 12) begin
          send_request(make_req(cmd_e'($urandom_range(1)), $urandom,
                                rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                                rand_pos(), rand_pos(), rand_pos(), rand_pos()));
        end else begin
          if ($urandom_range(3) != 0) begin
            if ($urandom_range(1) != 0) begin
              gx = pos_t'(nav_x + spread(20000));
              gy = pos_t'(nav_y + spread(20000));
              gz = pos_t'(body_z + spread(5000));
            end else begin
              gx = rand_pos();
              gy = rand_pos();
              gz = rand_pos();
            end
            send_request(make_req(CMD_SET, $urandom, rand_pos(), rand_pos(), rand_pos(),
                                  rand_pos(), rand_pos(), rand_pos(), gx, gy, gz));
          end
          n = $urandom_range(14, 4);
          for (j = 0; j < int'(n); j++) begin
            if ($urandom_range(99) < 85)
              clock_ms += cur_period + $urandom_range(5);
            else
              clock_ms += $urandom_range(cur_period);
            case ($urandom_range(9))
              0, 1, 2, 3, 4: body_z = pos_t'(body_z + spread(cur_settle / 2));
              5, 6, 7:       body_z = pos_t'(body_z + int'(cur_raise_thr) +
                                             int'($urandom_range(3000, 1)));
              8:             body_z = pos_t'(body_z - int'($urandom_range(5000)));
              default:       body_z = rand_pos();
            endcase
            nav_x = pos_t'(nav_x + spread(2000));
            nav_y = pos_t'(nav_y + spread(2000));
            if ($urandom_range(19) == 0)
              nav_z = POS_MAX - pos_t'($urandom_range(2000));
            else
              nav_z = pos_t'(body_z + spread(500));
            case ($urandom_range(9))
              0, 1, 2, 3, 4, 5, 6: begin
                mx = pos_t'(nav_x + spread(cur_move / 2));
                my = pos_t'(nav_y + spread(cur_move / 2));
              end
              7, 8: begin
                mx = pos_t'(nav_x + spread(70000));
                my = pos_t'(nav_y + spread(70000));
              end
              default: begin
                mx = rand_pos();
                my = rand_pos();
              end
            endcase
            send_request(make_req(CMD_TICK, clock_ms, mx, my, body_z, nav_x, nav_y, nav_z,
                                  rand_pos(), rand_pos(), rand_pos()));
          end
        end
      end
      pause_stream();
    end

    repeat (4) @(posedge clk_i);
    $display("Ran %0d requests (%0d set or evaluated) over the reset values and %0d settings.",
             sb.requests, sb.acted, settings);
    $display("Checked %0d results: %0d targets, %0d torque off, %0d torque on, %0d mismatches.",
             sb.checked, sb.targets, sb.torque_offs, sb.torque_ons, sb.errors);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
